[sv/mbrr_pkg.sv]
package mbrr_pkg;

	// Input command codes.
	localparam logic [1:0] CMD_REQUEST   = 2'd0;
	localparam logic [1:0] CMD_RX_BYTE   = 2'd1;
	localparam logic [1:0] CMD_END_FRAME = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_REG    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Frame status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_ADDR  = 2'd2;
	localparam logic [1:0] ST_CRC   = 2'd3;

	localparam logic [7:0]  FUNC_READ = 8'h03;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	// Request frame byte positions: six covered by the CRC, the last one ends the frame.
	localparam logic [2:0] REQ_CRC_BYTES = 3'd6;
	localparam logic [2:0] REQ_LAST      = 3'd7;

	// Depth of the operation queue between front and back.
	localparam int OPQ_DEPTH = 4;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] start_register;
		logic [4:0]  reg_count;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic [15:0] reg_value;
		logic [1:0]  status;
		logic        last;
	} result_t;

	typedef enum logic [1:0] {
		OP_REQUEST,
		OP_RX_BYTE,
		OP_END_FRAME
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [15:0] start_register;
		logic [4:0]  reg_count;
		logic [7:0]  rx_byte;
	} op_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_REQ,
		BS_CHECK,
		BS_FETCH,
		BS_REGOUT,
		BS_STATUS
	} back_state_t;

	// One byte of the Modbus CRC-16, reflected form.
	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[sv/mbrr_front.sv]
module mbrr_front #(
	parameter int MAX_REGS = 16
) (
	input  logic            push,
	output logic            full,
	input  mbrr_pkg::item_t item,
	input  logic            opq_full,
	output logic            opq_push,
	output mbrr_pkg::op_t   opq_op
);
	import mbrr_pkg::*;

	logic       cmd_known;
	logic [4:0] count_sat;

	// The request count is clamped to what the register store can hold.
	assign count_sat = (item.reg_count > 5'(MAX_REGS)) ? 5'(MAX_REGS) : item.reg_count;

	always_comb begin
		cmd_known = 1'b1;
		opq_op = '{kind: OP_RX_BYTE, start_register: item.start_register,
			reg_count: count_sat, rx_byte: item.rx_byte};
		unique case (item.cmd)
			CMD_REQUEST:   opq_op.kind = OP_REQUEST;
			CMD_RX_BYTE:   opq_op.kind = OP_RX_BYTE;
			CMD_END_FRAME: opq_op.kind = OP_END_FRAME;
			default:       cmd_known = 1'b0;
		endcase
	end

	// Unused commands are taken and dropped so they never reach the back end.
	assign full     = opq_full;
	assign opq_push = push && !opq_full && cmd_known;

endmodule

[sv/mbrr_opq.sv]
module mbrr_opq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mbrr_pkg::op_t op_in,
	output logic          full,
	input  logic          pop,
	output mbrr_pkg::op_t op_out,
	output logic          empty
);
	import mbrr_pkg::*;

	localparam int PTR_W = $clog2(OPQ_DEPTH);
	localparam int CNT_W = $clog2(OPQ_DEPTH + 1);

	op_t              slot_q [OPQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(OPQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign op_out  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= op_in;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(OPQ_DEPTH))
		else $error("operation queue count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("operation pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("operation popped from an empty queue");

endmodule

[sv/mbrr_back.sv]
module mbrr_back #(
	parameter int MAX_REGS    = 16,
	parameter int FRAME_BYTES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [7:0]        cfg_wr_data,
	input  logic              op_valid,
	input  mbrr_pkg::op_t     op,
	output logic              op_pop,
	input  logic              pop,
	output logic              empty,
	output mbrr_pkg::result_t result
);
	import mbrr_pkg::*;

	localparam int LEN_W = $clog2(FRAME_BYTES + 1);
	localparam int IDX_W = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
	localparam int OFF_W = (LEN_W > IDX_W) ? LEN_W : IDX_W + 1;
	localparam int CMP_W = (LEN_W > 7) ? LEN_W : 7;

	back_state_t      state_q, state_d;
	logic [7:0]       node_addr_q;
	logic [LEN_W-1:0] rx_len_q;
	logic [15:0]      crc_run_q;
	logic [15:0]      tail_q;
	logic [15:0]      hdr_q;
	logic [4:0]       exp_cnt_q;
	logic [15:0]      req_reg_q;
	logic [15:0]      req_crc_q;
	logic [2:0]       req_idx_q;
	logic [4:0]       rd_idx_q;
	logic [7:0]       rd_hi_q;
	logic [7:0]       rd_lo_q;
	logic             out_valid_q;
	result_t          out_q;
	logic [7:0]       mem_hi [MAX_REGS];
	logic [7:0]       mem_lo [MAX_REGS];

	logic             out_free;
	logic [CMP_W-1:0] want;
	logic             too_short;
	logic             bad_addr;
	logic             bad_crc;
	logic [7:0]       req_byte;
	logic             room;
	logic [OFF_W-1:0] off;
	logic [OFF_W-1:0] widx_full;
	logic             wr_store;
	logic             do_req_start;
	logic             do_rx;
	logic             req_step;
	logic             rd_start;
	logic             rd_next;
	logic             emit;
	result_t          emit_val;

	assign out_free  = !out_valid_q || pop;
	assign empty     = !out_valid_q;
	assign result    = out_q;

	assign want      = CMP_W'(5) + CMP_W'({exp_cnt_q, 1'b0});
	assign too_short = CMP_W'(rx_len_q) < want;
	assign bad_addr  = (hdr_q[15:8] != node_addr_q) || (hdr_q[7:0] != FUNC_READ);
	assign bad_crc   = {tail_q[7:0], tail_q[15:8]} != crc_run_q;

	assign room      = rx_len_q < LEN_W'(FRAME_BYTES);
	assign off       = OFF_W'(rx_len_q) - OFF_W'(3);
	assign widx_full = off >> 1;
	assign wr_store  = (rx_len_q >= LEN_W'(3)) && (widx_full < OFF_W'(MAX_REGS));

	always_comb begin
		case (req_idx_q)
			3'd0:    req_byte = node_addr_q;
			3'd1:    req_byte = FUNC_READ;
			3'd2:    req_byte = req_reg_q[15:8];
			3'd3:    req_byte = req_reg_q[7:0];
			3'd4:    req_byte = 8'h00;
			3'd5:    req_byte = {3'b000, exp_cnt_q};
			3'd6:    req_byte = req_crc_q[7:0];
			default: req_byte = req_crc_q[15:8];
		endcase
	end

	always_comb begin
		state_d      = state_q;
		op_pop       = 1'b0;
		do_req_start = 1'b0;
		do_rx        = 1'b0;
		req_step     = 1'b0;
		rd_start     = 1'b0;
		rd_next      = 1'b0;
		emit         = 1'b0;
		emit_val     = '0;
		unique case (state_q)
			BS_IDLE: begin
				if (op_valid) begin
					op_pop = 1'b1;
					unique case (op.kind)
						OP_REQUEST: begin
							do_req_start = 1'b1;
							state_d      = BS_REQ;
						end
						OP_RX_BYTE:   do_rx = 1'b1;
						OP_END_FRAME: state_d = BS_CHECK;
						default:      ;
					endcase
				end
			end
			BS_REQ: begin
				if (out_free) begin
					emit             = 1'b1;
					emit_val.kind    = KIND_TX;
					emit_val.tx_byte = req_byte;
					emit_val.last    = (req_idx_q == REQ_LAST);
					req_step         = 1'b1;
					if (req_idx_q == REQ_LAST) begin
						state_d = BS_IDLE;
					end
				end
			end
			BS_CHECK: begin
				if (out_free) begin
					emit          = 1'b1;
					emit_val.kind = KIND_STATUS;
					emit_val.last = 1'b1;
					state_d       = BS_IDLE;
					if (too_short) begin
						emit_val.status = ST_SHORT;
					end else if (bad_addr) begin
						emit_val.status = ST_ADDR;
					end else if (bad_crc) begin
						emit_val.status = ST_CRC;
					end else if (exp_cnt_q != 5'd0) begin
						emit     = 1'b0;
						rd_start = 1'b1;
						state_d  = BS_FETCH;
					end else begin
						emit_val.status = ST_OK;
					end
				end
			end
			BS_FETCH: state_d = BS_REGOUT;
			BS_REGOUT: begin
				if (out_free) begin
					emit               = 1'b1;
					emit_val.kind      = KIND_REG;
					emit_val.reg_value = {rd_hi_q, rd_lo_q};
					rd_next            = 1'b1;
					state_d = ((rd_idx_q + 5'd1) == exp_cnt_q) ? BS_STATUS : BS_FETCH;
				end
			end
			BS_STATUS: begin
				if (out_free) begin
					emit            = 1'b1;
					emit_val.kind   = KIND_STATUS;
					emit_val.status = ST_OK;
					emit_val.last   = 1'b1;
					state_d         = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_addr_q <= 8'd1;
			rx_len_q    <= '0;
			crc_run_q   <= CRC_INIT;
			tail_q      <= '0;
			hdr_q       <= '0;
			exp_cnt_q   <= '0;
			req_idx_q   <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				node_addr_q <= cfg_wr_data;
			end
			if (do_req_start) begin
				rx_len_q  <= '0;
				crc_run_q <= CRC_INIT;
				tail_q    <= '0;
				hdr_q     <= '0;
				exp_cnt_q <= op.reg_count;
				req_idx_q <= '0;
			end else if (do_rx && room) begin
				if (rx_len_q >= LEN_W'(2)) begin
					crc_run_q <= crc_add(crc_run_q, tail_q[15:8]);
				end
				tail_q <= {tail_q[7:0], op.rx_byte};
				if (rx_len_q == '0) begin
					hdr_q <= {op.rx_byte, 8'h00};
				end else if (rx_len_q == LEN_W'(1)) begin
					hdr_q <= {hdr_q[15:8], op.rx_byte};
				end
				rx_len_q <= rx_len_q + LEN_W'(1);
			end
			if (req_step) begin
				req_idx_q <= req_idx_q + 3'd1;
			end
			if (rd_start) begin
				rd_idx_q <= '0;
			end else if (rd_next) begin
				rd_idx_q <= rd_idx_q + 5'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_req_start) begin
			req_reg_q <= op.start_register;
			req_crc_q <= CRC_INIT;
		end else if (req_step && (req_idx_q < REQ_CRC_BYTES)) begin
			req_crc_q <= crc_add(req_crc_q, req_byte);
		end
		if (emit) begin
			out_q <= emit_val;
		end
	end

	// Register store: byte-wide halves, one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (do_rx && room && wr_store) begin
			if (!off[0]) begin
				mem_hi[widx_full[IDX_W-1:0]] <= op.rx_byte;
			end else begin
				mem_lo[widx_full[IDX_W-1:0]] <= op.rx_byte;
			end
		end
		if (state_q == BS_FETCH) begin
			rd_hi_q <= mem_hi[rd_idx_q[IDX_W-1:0]];
			rd_lo_q <= mem_lo[rd_idx_q[IDX_W-1:0]];
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_len_q <= LEN_W'(FRAME_BYTES))
		else $error("receive length beyond frame buffer");

	a_regout_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BS_REGOUT) |-> (rd_idx_q < exp_cnt_q))
		else $error("register read past the requested count");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.kind == KIND_STATUS)) |-> out_q.last)
		else $error("status result not marked last");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		op_pop |-> (state_q == BS_IDLE) && op_valid)
		else $error("operation taken while busy");

endmodule

[sv/modbus_rtu_read_regs_master.sv]
// Modbus RTU master for function 0x03 (read holding registers). An input transaction
// carries one command: a request makes the block send the 8-byte request frame (node
// address, function, start register and count big-endian, CRC-16 low byte first) as eight
// kind-0 results and clears the receive state; a received byte is stored (up to FRAME_BYTES,
// the rest are dropped) and gives no result; an end-of-frame command checks the reply for
// length, then address and function, then CRC, and gives either the register values as
// kind-1 results followed by an ok status, or a single error status. The last result of
// each command has last set. A request count above MAX_REGS is clamped to MAX_REGS. A
// front stage decodes commands into a four-entry operation queue, so up to four commands
// are taken while the back end is still busy; the back end works on one operation at a
// time and takes the next from the queue only while idle. A received byte is stored as
// it is taken, a request is taken and then its frame bytes are sent in order, and an end
// of frame is taken and then checked; it ends with the checks when it ends in an error or
// in the bare ok status of a zero count, while with registers to return each value is
// read from the register store through its registered read port and then sent. Results
// wait in one output register, and the back end stalls while it is full and not being
// popped. The node address register resets to 1 and should only be written while no
// transaction is in flight.
module modbus_rtu_read_regs_master #(
	parameter int MAX_REGS    = 16,
	parameter int FRAME_BYTES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  mbrr_pkg::item_t   item,
	input  logic              pop,
	output logic              empty,
	output mbrr_pkg::result_t result,
	input  logic              cfg_wr_en,
	input  logic [7:0]        cfg_wr_data
);
	import mbrr_pkg::*;

	logic opq_full;
	logic opq_push;
	op_t  opq_in;
	logic opq_pop;
	op_t  opq_out;
	logic opq_empty;

	// Front end: decodes each accepted command into a queue operation.
	mbrr_front #(
		.MAX_REGS(MAX_REGS)
	) u_front (
		.push    (push),
		.full    (full),
		.item    (item),
		.opq_full(opq_full),
		.opq_push(opq_push),
		.opq_op  (opq_in)
	);

	// Decouples command intake from frame generation and checking.
	mbrr_opq u_opq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (opq_push),
		.op_in (opq_in),
		.full  (opq_full),
		.pop   (opq_pop),
		.op_out(opq_out),
		.empty (opq_empty)
	);

	// Back end: owns the receive state, the register store and the result register.
	mbrr_back #(
		.MAX_REGS   (MAX_REGS),
		.FRAME_BYTES(FRAME_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.op_valid   (!opq_empty),
		.op         (opq_out),
		.op_pop     (opq_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

endmodule

[test/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mbrr_pkg::*;

	// The block's own sizes, passed down explicitly so that the predictor agrees with them.
	localparam int MAX_WORDS   = 16;
	localparam int FRAME_LIMIT = 64;

	// The fourth command code is unused by the block and must leave it untouched.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Random part size, cycles allowed for trailing work, and the receiver hold-off.
	localparam int ITEM_GOAL    = 280;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_AT      = 62;
	localparam int HOLD_CYCLES  = 300;

	// Shapes of slave reply that the stimulus can build.
	typedef enum logic [2:0] {
		RP_GOOD,
		RP_SHORT,
		RP_BAD_ADDR,
		RP_BAD_FUNC,
		RP_BAD_CRC,
		RP_OVERLONG
	} reply_shape_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_REPLY
	} row_act_t;

	// One row of the directed table. A row either offers one input transaction or a
	// whole reply frame. Where typed is set, the status of an end of frame is spelled
	// out here instead of being taken from the predictor.
	typedef struct packed {
		row_act_t     act;
		item_t        it;
		reply_shape_t shape;
		logic [4:0]   words;
		logic         typed;
		logic [1:0]   typed_st;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [20] = '{
		// End of frame before any request: count is zero and nothing was received.
		'{ROW_ITEM,  '{CMD_END_FRAME, 16'h0000, 5'd0, 8'h00}, RP_GOOD, 5'd0, 1'b1, ST_SHORT},
		// The unused command must produce nothing.
		'{ROW_ITEM,  '{CMD_UNUSED, 16'hFFFF, 5'd31, 8'hFF}, RP_GOOD, 5'd0, 1'b0, ST_OK},
		'{ROW_ITEM,  '{CMD_REQUEST, 16'h0000, 5'd1, 8'h00}, RP_GOOD, 5'd0, 1'b0, ST_OK},
		'{ROW_REPLY, '0, RP_GOOD, 5'd1, 1'b0, ST_OK},
		'{ROW_ITEM,  '{CMD_END_FRAME, 16'h0000, 5'd0, 8'h00}, RP_GOOD, 5'd0, 1'b0, ST_OK},
		// A second end of frame must repeat the same answer.
		'{ROW_ITEM,  '{CMD_END_FRAME, 16'hFFFF, 5'd31, 8'hFF}, RP_GOOD, 5'd0, 1'b0, ST_OK},
		// Count above the register limit is clamped to sixteen in the frame and the check.
		'{ROW_ITEM,  '{CMD_REQUEST, 16'hFFFF, 5'd31, 8'hFF}, RP_GOOD, 5'd0, 1'b0, ST_OK},
		'{ROW_ITEM,  '{CMD_END_FRAME, 16'h0000, 5'd0, 8'h00}, RP_GOOD, 5'd0, 1'b1, ST_SHORT},
		// Count zero: a bare five byte reply yields only the ok status.
		'{ROW_ITEM,  '{CMD_REQUEST, 16'h8000, 5'd0, 8'h00}, RP_GOOD, 5'd0, 1'b0, ST_OK},
		'{ROW_REPLY, '0, RP_GOOD, 5'd0, 1'b0, ST_OK},
		'{ROW_ITEM,  '{CMD_END_FRAME, 16'h0000, 5'd0, 8'h00}, RP_GOOD, 5'd0, 1'b1, ST_OK},
		'{ROW_ITEM,  '{CMD_REQUEST, 16'h00FF, 5'd2, 8'h00}, RP_GOOD, 5'd0, 1'b0, ST_OK},
		'{ROW_REPLY, '0, RP_BAD_ADDR, 5'd2, 1'b0, ST_OK},
		'{ROW_ITEM,  '{CMD_END_FRAME, 16'h0000, 5'd0, 8'h00}, RP_GOOD, 5'd0, 1'b1, ST_ADDR},
		'{ROW_ITEM,  '{CMD_REQUEST, 16'h7F00, 5'd1, 8'h00}, RP_GOOD, 5'd0, 1'b0, ST_OK},
		'{ROW_REPLY, '0, RP_BAD_FUNC, 5'd1, 1'b0, ST_OK},
		'{ROW_ITEM,  '{CMD_END_FRAME, 16'h0000, 5'd0, 8'h00}, RP_GOOD, 5'd0, 1'b1, ST_ADDR},
		'{ROW_ITEM,  '{CMD_REQUEST, 16'h1234, 5'd1, 8'h00}, RP_GOOD, 5'd0, 1'b0, ST_OK},
		'{ROW_REPLY, '0, RP_BAD_CRC, 5'd1, 1'b0, ST_OK},
		'{ROW_ITEM,  '{CMD_END_FRAME, 16'h0000, 5'd0, 8'h00}, RP_GOOD, 5'd0, 1'b1, ST_CRC}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	item_t      item = '0;
	logic       pop = 1'b0;
	logic       empty;
	result_t    result;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;

	// Predictor copy of the master: configured address plus the receive state.
	logic [7:0]  node_addr = 8'h01;
	logic [6:0]  rx_len = '0;
	logic [15:0] rx_crc = CRC_INIT;
	logic [15:0] rx_tail = '0;
	logic [15:0] rx_head = '0;
	logic [4:0]  req_count = '0;
	logic [15:0] reg_words [MAX_WORDS];

	// Results the master still owes, oldest first.
	result_t master_out_q [$];

	int fed_items = 0;
	int frame_no = 0;
	int burst_left = 0;
	int seen_results = 0;
	int fail_count = 0;
	int hold_left = 0;

	modbus_rtu_read_regs_master #(
		.MAX_REGS   (MAX_WORDS),
		.FRAME_BYTES(FRAME_LIMIT)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.pop        (pop),
		.empty      (empty),
		.result     (result),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #10 clk = ~clk;

	// Modbus CRC-16, one byte at a time, reflected polynomial.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// Works out what the master answers to one accepted transaction and advances the
	// predictor state the same way the block does.
	function automatic void mb_master_step(input item_t it, ref result_t outs[$]);
		logic [7:0]  frame [8];
		logic [15:0] crc;
		logic [4:0]  n;
		result_t     r;
		int          pos;
		int          idx;
		case (it.cmd)
			CMD_REQUEST: begin
				n = (it.reg_count > 5'(MAX_WORDS)) ? 5'(MAX_WORDS) : it.reg_count;
				frame[0] = node_addr;
				frame[1] = FUNC_READ;
				frame[2] = it.start_register[15:8];
				frame[3] = it.start_register[7:0];
				frame[4] = 8'h00;
				frame[5] = {3'b000, n};
				crc = CRC_INIT;
				for (int i = 0; i < 6; i++) crc = crc16_byte(crc, frame[i]);
				frame[6] = crc[7:0];
				frame[7] = crc[15:8];
				for (int i = 0; i < 8; i++) begin
					r = '0;
					r.kind = KIND_TX;
					r.tx_byte = frame[i];
					r.last = (i == 7);
					outs.push_back(r);
				end
				rx_len = '0;
				rx_crc = CRC_INIT;
				rx_tail = '0;
				rx_head = '0;
				req_count = n;
			end
			CMD_RX_BYTE: begin
				pos = int'(rx_len);
				if (pos < FRAME_LIMIT) begin
					// The running CRC trails by two bytes, so the byte leaving the tail is added.
					if (pos >= 2) rx_crc = crc16_byte(rx_crc, rx_tail[15:8]);
					rx_tail = {rx_tail[7:0], it.rx_byte};
					if (pos == 0) rx_head = {it.rx_byte, 8'h00};
					else if (pos == 1) rx_head[7:0] = it.rx_byte;
					if (pos >= 3) begin
						idx = (pos - 3) / 2;
						if (idx < MAX_WORDS) begin
							if ((pos - 3) % 2 == 0) reg_words[idx][15:8] = it.rx_byte;
							else reg_words[idx][7:0] = it.rx_byte;
						end
					end
					rx_len = rx_len + 7'd1;
				end
			end
			CMD_END_FRAME: begin
				r = '0;
				r.kind = KIND_STATUS;
				r.last = 1'b1;
				if (int'(rx_len) < 5 + 2 * int'(req_count)) begin
					r.status = ST_SHORT;
				end else if (rx_head != {node_addr, FUNC_READ}) begin
					r.status = ST_ADDR;
				end else if ({rx_tail[7:0], rx_tail[15:8]} != rx_crc) begin
					r.status = ST_CRC;
				end else begin
					for (int i = 0; i < int'(req_count); i++) begin
						result_t w;
						w = '0;
						w.kind = KIND_REG;
						w.reg_value = reg_words[i];
						outs.push_back(w);
					end
					r.status = ST_OK;
				end
				outs.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function automatic item_t any_item(input logic [1:0] cmd);
		item_t it;
		it = item_t'($urandom);
		it.cmd = cmd;
		return it;
	endfunction

	// Offers one transaction in the sender's burst pattern and waits until it is taken.
	// Push changes only at falling edges; acceptance is seen at the rising edge.
	task automatic offer(input item_t it, input logic typed, input logic [1:0] typed_st);
		result_t outs [$];
		result_t r;
		int      gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				push <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		mb_master_step(it, outs);
		if (typed) begin
			// The directed table fixes the status of this end of frame.
			r = '0;
			r.kind = KIND_STATUS;
			r.status = typed_st;
			r.last = 1'b1;
			master_out_q.push_back(r);
		end else begin
			foreach (outs[i]) master_out_q.push_back(outs[i]);
		end
		if (it.cmd != CMD_UNUSED) fed_items++;
	endtask

	// Builds a slave reply for the current address and feeds it byte by byte.
	task automatic send_reply(input reply_shape_t shape, input int words);
		logic [7:0]  bytes [$];
		logic [15:0] crc;
		int          keep;
		item_t       it;
		if (shape == RP_BAD_ADDR)
			bytes.push_back(node_addr + 8'd1 + 8'($urandom_range(0, 254)));
		else
			bytes.push_back(node_addr);
		if (shape == RP_BAD_FUNC)
			bytes.push_back(FUNC_READ ^ 8'($urandom_range(1, 255)));
		else
			bytes.push_back(FUNC_READ);
		bytes.push_back(8'(2 * words));
		repeat (2 * words) bytes.push_back(8'($urandom));
		// An overlong reply is a valid 64 byte frame with junk behind it that is dropped.
		if (shape == RP_OVERLONG)
			while (bytes.size() < FRAME_LIMIT - 2) bytes.push_back(8'($urandom));
		crc = CRC_INIT;
		foreach (bytes[i]) crc = crc16_byte(crc, bytes[i]);
		bytes.push_back(crc[7:0]);
		bytes.push_back(crc[15:8]);
		case (shape)
			RP_BAD_CRC:
				bytes[bytes.size() - 1 - $urandom_range(0, 1)] ^= 8'd1 << $urandom_range(0, 7);
			RP_SHORT: begin
				keep = $urandom_range(0, 4 + 2 * words);
				while (bytes.size() > keep) void'(bytes.pop_back());
			end
			RP_OVERLONG:
				repeat ($urandom_range(1, 10)) bytes.push_back(8'($urandom));
			default: ;
		endcase
		foreach (bytes[i]) begin
			it = any_item(CMD_RX_BYTE);
			it.rx_byte = bytes[i];
			offer(it, 1'b0, ST_OK);
		end
	endtask

	// Drops push and waits until every owed result is out, then gives the block time to
	// finish received bytes still queued inside, which produce nothing visible.
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		burst_left = 0;
		while (master_out_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_node_addr(input logic [7:0] id);
		settle();
		cfg_wr_data <= id;
		cfg_wr_en <= 1'b1;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		node_addr = id;
	endtask

	// Random request/reply/check sequences. Many are well formed with random content;
	// the rest skip the request, mangle the reply or slip stray commands in.
	task automatic run_frames(input int item_goal);
		item_t        it;
		reply_shape_t shape;
		int           cnt;
		int           words;
		int           pick;
		while (fed_items < item_goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) cnt = 0;
			else if (pick < 75) cnt = $urandom_range(1, 4);
			else if (pick < 90) cnt = $urandom_range(5, 16);
			else cnt = $urandom_range(17, 31);
			if (frame_no == 0) cnt = 16;
			if (frame_no < 2 || $urandom_range(0, 11) != 0) begin
				it = any_item(CMD_REQUEST);
				it.reg_count = 5'(cnt);
				offer(it, 1'b0, ST_OK);
			end
			words = (cnt > MAX_WORDS) ? MAX_WORDS : cnt;
			if ($urandom_range(0, 9) == 0) words = $urandom_range(0, 6);
			pick = $urandom_range(0, 99);
			if (pick < 58) shape = RP_GOOD;
			else if (pick < 68) shape = RP_SHORT;
			else if (pick < 76) shape = RP_BAD_ADDR;
			else if (pick < 83) shape = RP_BAD_FUNC;
			else if (pick < 95) shape = RP_BAD_CRC;
			else shape = RP_OVERLONG;
			if (frame_no == 1) shape = RP_OVERLONG;
			send_reply(shape, words);
			if ($urandom_range(0, 6) == 0)
				repeat ($urandom_range(1, 3)) offer(any_item(2'($urandom_range(0, 3))), 1'b0, ST_OK);
			offer(any_item(CMD_END_FRAME), 1'b0, ST_OK);
			if ($urandom_range(0, 6) == 0) offer(any_item(CMD_END_FRAME), 1'b0, ST_OK);
			frame_no++;
		end
	endtask

	// Compares one accepted result with the oldest owed one.
	task automatic check_result(input result_t got);
		result_t want;
		seen_results++;
		// One long hold-off, so that the block fills up and pushes back on the sender.
		if (seen_results == HOLD_AT) hold_left = HOLD_CYCLES;
		if (master_out_q.size() == 0) begin
			if (fail_count < 10)
				$display("unexpected result: kind %0d tx %h value %h status %0d last %0b",
					got.kind, got.tx_byte, got.reg_value, got.status, got.last);
			fail_count++;
		end else begin
			want = master_out_q.pop_front();
			if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
					got.reg_value !== want.reg_value || got.status !== want.status ||
					got.last !== want.last) begin
				if (fail_count < 10) begin
					$display("mismatch at result %0d (expected/actual):", seen_results);
					$display("  kind %0d/%0d tx %h/%h value %h/%h status %0d/%0d last %0b/%0b",
						want.kind, got.kind, want.tx_byte, got.tx_byte, want.reg_value,
						got.reg_value, want.status, got.status, want.last, got.last);
				end
				fail_count++;
			end
		end
	endtask

	// Result side: pop follows a random eight-bit pattern, which is sometimes all ones
	// so that stretches without stalls occur, apart from the one long hold-off.
	initial begin
		logic [7:0] pat;
		int         pat_pos;
		pat = '1;
		pat_pos = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				if (pat_pos == 0) pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
				pop <= pat[pat_pos];
				pat_pos = (pat_pos + 1) % 8;
			end
			@(posedge clk);
			if (pop && !empty) check_result(result);
		end
	end

	// Stimulus: reset, directed table at the reset address, then random phases at the
	// extreme addresses, a random one, and back to the reset value.
	initial begin
		logic [7:0] id;
		int         base;
		foreach (reg_words[i]) reg_words[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].act == ROW_REPLY)
				send_reply(DIR_ROWS[i].shape, int'(DIR_ROWS[i].words));
			else
				offer(DIR_ROWS[i].it, DIR_ROWS[i].typed, DIR_ROWS[i].typed_st);
		end

		base = fed_items;
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: id = 8'h00;
				1: id = 8'hFF;
				2: id = 8'($urandom_range(2, 254));
				default: id = 8'h01;
			endcase
			set_node_addr(id);
			run_frames(base + ITEM_GOAL * (p + 1) / 4);
		end

		settle();
		if (fail_count == 0)
			$display("modbus_rtu_read_regs_master test passed");
		else
			$display("modbus_rtu_read_regs_master test failed");
		$finish;
	end

	// Guard against a hang: far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("modbus_rtu_read_regs_master test failed");
		$finish;
	end

endmodule
